### rtl/gtl_pkg.sv
// Shared types, codes and helpers for the glyph text layout block.
package gtl_pkg;

   // Field widths fixed by the item format
   localparam int CODE_W     = 8;
   localparam int COORD_W    = 16;
   localparam int TEXEL_W    = 8;
   localparam int SCALE_W    = 4;
   localparam int POS_X_W    = 20;
   localparam int POS_Y_W    = 12;
   localparam int TEX_U_W    = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Scaled quantities: texel * scale, and (lead + width + trail) * scale
   localparam int PROD_W = 12;
   localparam int ADV_W  = 14;

   // Widest sum that the x clamp accepts (pen of 32 bits plus carry)
   localparam int CLAMP_W = 33;

   // Default parameter values
   localparam int GLYPH_COUNT_DEF = 256;
   localparam int PEN_BITS_DEF    = 20;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PLACE = 1'b1;

   // Record kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_SIZE   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_SCALE  = 1'b1;

   localparam logic [TEXEL_W-1:0] LINE_HEIGHT_RST = 8'd16;
   localparam logic [SCALE_W-1:0] TEXT_SCALE_RST  = 4'd3;

   // Record slots within one place item: six quad corners then the size record
   localparam int REC_W = 3;
   localparam logic [REC_W-1:0] REC_CORNER_0 = 3'd0;
   localparam logic [REC_W-1:0] REC_CORNER_1 = 3'd1;
   localparam logic [REC_W-1:0] REC_CORNER_2 = 3'd2;
   localparam logic [REC_W-1:0] REC_CORNER_3 = 3'd3;
   localparam logic [REC_W-1:0] REC_CORNER_4 = 3'd4;
   localparam logic [REC_W-1:0] REC_CORNER_5 = 3'd5;
   localparam logic [REC_W-1:0] REC_SIZE     = 3'd6;

   localparam logic [POS_X_W-1:0] POS_X_MAX = {POS_X_W{1'b1}};

   typedef struct packed {
      logic               visible;
      logic [COORD_W-1:0] atlas_u;
      logic [TEXEL_W-1:0] span;
      logic [TEXEL_W-1:0] lead;
      logic [TEXEL_W-1:0] trail;
   } glyph_entry_type;

   function automatic logic [POS_X_W-1:0] clamp_pos_x(input logic [CLAMP_W-1:0] v);
      if (v > CLAMP_W'(POS_X_MAX)) begin
         return POS_X_MAX;
      end
      return v[POS_X_W-1:0];
   endfunction

endpackage

### rtl/gtl_glyph_store.sv
// Glyph table: entry memory with per-entry valid flags and a registered lookup.
module gtl_glyph_store
   import gtl_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic                rd_en,
   input  logic [CODE_W-1:0]   code,
   input  glyph_entry_type     wr_entry,
   output glyph_entry_type     rd_entry,
   output logic                rd_hit
);

   localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam logic [CODE_W:0] CODE_LIMIT = (CODE_W + 1)'(GLYPH_COUNT);

   glyph_entry_type        mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0] valid_ff;
   glyph_entry_type        rd_entry_ff;
   logic                   rd_hit_ff;

   logic             in_range;
   logic [IDX_W-1:0] idx;

   assign in_range = {1'b0, code} < CODE_LIMIT;
   assign idx      = code[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en && in_range) begin
            valid_ff[idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= in_range && valid_ff[idx];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_hit   = rd_hit_ff;

endmodule

### rtl/glyph_text_layout.sv
// Top level of the glyph text layout block: pen tracking and record emission.
//
// Usage: req_ beats carry either a glyph table write (command write) or a
// character to place (command place). A write is absorbed on its accept edge
// and yields no rsp_ beat. A place looks up its glyph, moves the pen, and
// yields six vertex beats for a visible glyph, plus one size beat when
// end_of_string is set; rsp_last marks the final beat of each place.
// csr_ writes set line height and text scale; write them only while idle.
// Pipeline: the glyph lookup register, then the pen update and corner math into
// the record sequencer, then the output register that drives the rsp_ beat.
// Throughput: one rsp_ beat per cycle while rsp_stall is low; a visible glyph
// yields six beats (seven with a size record); writes and places that produce
// nothing flow at one per cycle while no earlier place holds the input side.
// The record sequencer after the pen math sets the beat rate.
// Reset clears all glyph valid flags, the pen, and the lookup, sequencer and
// output stages, and loads line height 16 and scale 3. While rsp_stall is high
// the output beat holds; the sequencer and then the lookup stage fill, and
// req_stall rises once the lookup stage cannot drain.
module glyph_text_layout
   import gtl_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
   parameter int PEN_BITS    = PEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [CODE_W-1:0]     req_char_code,
   input  logic                  req_glyph_visible,
   input  logic [COORD_W-1:0]    req_glyph_tex_coord,
   input  logic [TEXEL_W-1:0]    req_glyph_tex_width,
   input  logic [TEXEL_W-1:0]    req_glyph_lead,
   input  logic [TEXEL_W-1:0]    req_glyph_trail,
   input  logic                  req_end_of_string,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_record_kind,
   output logic [POS_X_W-1:0]    rsp_pos_x,
   output logic [POS_Y_W-1:0]    rsp_pos_y,
   output logic [TEX_U_W-1:0]    rsp_tex_u,
   output logic [TEXEL_W-1:0]    rsp_tex_v,
   output logic                  rsp_last,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUM_W = ((PEN_BITS > ADV_W) ? PEN_BITS : ADV_W) + 1;
   localparam logic [PEN_BITS-1:0] PEN_MAX = {PEN_BITS{1'b1}};

   // ---------------------------------------------------------------- config
   logic [TEXEL_W-1:0] cell_height_ff;
   logic [SCALE_W-1:0] text_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_height_ff <= LINE_HEIGHT_RST;
         text_scale_ff  <= TEXT_SCALE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINE_HEIGHT: cell_height_ff <= csr_data[TEXEL_W-1:0];
            CSR_TEXT_SCALE:  text_scale_ff  <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- input accept
   logic req_accept;
   logic a_leave;
   logic a_valid_ff;
   logic a_eos_ff;

   // Hold the input side only while a looked-up place cannot drain
   assign req_stall  = a_valid_ff && !a_leave;
   assign req_accept = req_valid && !req_stall;

   glyph_entry_type wr_entry;
   glyph_entry_type a_entry;
   logic            a_hit;

   assign wr_entry = '{
      visible: req_glyph_visible,
      atlas_u: req_glyph_tex_coord,
      span:    req_glyph_tex_width,
      lead:    req_glyph_lead,
      trail:   req_glyph_trail
   };

   gtl_glyph_store #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_accept && (req_command == CMD_WRITE)),
      .rd_en    (req_accept && (req_command == CMD_PLACE)),
      .code     (req_char_code),
      .wr_entry (wr_entry),
      .rd_entry (a_entry),
      .rd_hit   (a_hit)
   );

   // Lookup stage: a place item waits here with its glyph entry
   logic a_valid_in;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept && (req_command == CMD_PLACE)) begin
         a_valid_in = 1'b1;
      end else if (a_leave) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_command == CMD_PLACE)) begin
         a_eos_ff <= req_end_of_string;
      end
   end

   // -------------------------------------------------------------- pen math
   logic [PEN_BITS-1:0] pen_ff;
   logic [PROD_W-1:0]   lead_sc;
   logic [PROD_W-1:0]   wid_sc;
   logic [PROD_W-1:0]   height_sc;
   logic [ADV_W-1:0]    adv_sc;
   logic [SUM_W-1:0]    pen1_sum;
   logic [PEN_BITS-1:0] pen1;
   logic [SUM_W-1:0]    x1_sum;
   logic [SUM_W-1:0]    pen2_sum;
   logic [PEN_BITS-1:0] pen2;
   logic [PEN_BITS-1:0] pen_after;
   logic [PEN_BITS-1:0] width_raw;
   logic [PEN_BITS-1:0] pen_in;
   logic                a_vis;
   logic                a_has_rec;

   assign lead_sc   = PROD_W'(a_entry.lead) * PROD_W'(text_scale_ff);
   assign wid_sc    = PROD_W'(a_entry.span) * PROD_W'(text_scale_ff);
   assign height_sc = PROD_W'(cell_height_ff) * PROD_W'(text_scale_ff);
   assign adv_sc    = (ADV_W'(a_entry.lead) + ADV_W'(a_entry.span)
                       + ADV_W'(a_entry.trail)) * ADV_W'(text_scale_ff);

   // Pen at the glyph's left edge, saturated
   assign pen1_sum = SUM_W'(pen_ff) + SUM_W'(lead_sc);
   assign pen1     = (|pen1_sum[SUM_W-1:PEN_BITS]) ? PEN_MAX : pen1_sum[PEN_BITS-1:0];
   assign x1_sum   = SUM_W'(pen1) + SUM_W'(wid_sc);

   // Advances only add, so one saturating add of the whole advance matches two
   assign pen2_sum = SUM_W'(pen_ff) + SUM_W'(adv_sc);
   assign pen2     = (|pen2_sum[SUM_W-1:PEN_BITS]) ? PEN_MAX : pen2_sum[PEN_BITS-1:0];

   assign pen_after = a_hit ? pen2 : pen_ff;
   assign width_raw = (pen_after > PEN_BITS'(text_scale_ff))
                      ? pen_after - PEN_BITS'(text_scale_ff) : '0;

   assign a_vis     = a_hit && a_entry.visible;
   assign a_has_rec = a_vis || a_eos_ff;

   always_comb begin
      pen_in = pen_ff;
      if (a_leave) begin
         pen_in = a_eos_ff ? '0 : pen_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else begin
         pen_ff <= pen_in;
      end
   end

   // ------------------------------------------------------ record sequencer
   logic                b_valid_ff;
   logic [REC_W-1:0]    b_cnt_ff;
   logic [REC_W-1:0]    b_last_ff;
   logic [POS_X_W-1:0]  b_x0_ff;
   logic [POS_X_W-1:0]  b_x1_ff;
   logic [POS_X_W-1:0]  b_w_ff;
   logic [POS_Y_W-1:0]  b_h_ff;
   logic [COORD_W-1:0]  b_u0_ff;
   logic [TEX_U_W-1:0]  b_u1_ff;
   logic [TEXEL_W-1:0]  b_lh_ff;

   logic rsp_valid_ff;
   logic rsp_load;
   logic b_done;
   logic b_free;
   logic a_to_b;

   assign rsp_load = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_done   = rsp_load && (b_cnt_ff == b_last_ff);
   assign b_free   = !b_valid_ff || b_done;
   // Places that emit nothing just move the pen and drop out
   assign a_leave  = a_valid_ff && (!a_has_rec || b_free);
   assign a_to_b   = a_leave && a_has_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_cnt_ff   <= REC_CORNER_0;
         b_last_ff  <= REC_SIZE;
      end else if (a_to_b) begin
         b_valid_ff <= 1'b1;
         b_cnt_ff   <= a_vis ? REC_CORNER_0 : REC_SIZE;
         b_last_ff  <= a_eos_ff ? REC_SIZE : REC_CORNER_5;
      end else if (b_done) begin
         b_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         b_cnt_ff <= b_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (a_to_b) begin
         b_x0_ff <= clamp_pos_x(CLAMP_W'(pen1));
         b_x1_ff <= clamp_pos_x(CLAMP_W'(x1_sum));
         b_w_ff  <= clamp_pos_x(CLAMP_W'(width_raw));
         b_h_ff  <= height_sc;
         b_u0_ff <= a_entry.atlas_u;
         b_u1_ff <= TEX_U_W'(a_entry.atlas_u) + TEX_U_W'(a_entry.span);
         b_lh_ff <= cell_height_ff;
      end
   end

   // Pick the corner: right edge and top edge per slot of the quad
   logic sel_right;
   logic sel_top;
   logic sel_size;

   always_comb begin
      sel_right = 1'b0;
      sel_top   = 1'b0;
      sel_size  = 1'b0;
      unique case (b_cnt_ff)
         REC_CORNER_0: ;
         REC_CORNER_1: sel_right = 1'b1;
         REC_CORNER_2: sel_top   = 1'b1;
         REC_CORNER_3: sel_top   = 1'b1;
         REC_CORNER_4: sel_right = 1'b1;
         REC_CORNER_5: begin
            sel_right = 1'b1;
            sel_top   = 1'b1;
         end
         default:      sel_size  = 1'b1;
      endcase
   end

   // --------------------------------------------------------- output beat
   logic                rsp_kind_ff;
   logic [POS_X_W-1:0]  rsp_x_ff;
   logic [POS_Y_W-1:0]  rsp_y_ff;
   logic [TEX_U_W-1:0]  rsp_u_ff;
   logic [TEXEL_W-1:0]  rsp_v_ff;
   logic                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_last_ff <= (b_cnt_ff == b_last_ff);
         if (sel_size) begin
            rsp_kind_ff <= KIND_SIZE;
            rsp_x_ff    <= b_w_ff;
            rsp_y_ff    <= b_h_ff;
            rsp_u_ff    <= '0;
            rsp_v_ff    <= '0;
         end else begin
            rsp_kind_ff <= KIND_VERTEX;
            rsp_x_ff    <= sel_right ? b_x1_ff : b_x0_ff;
            rsp_y_ff    <= sel_top ? b_h_ff : '0;
            rsp_u_ff    <= sel_right ? b_u1_ff : TEX_U_W'(b_u0_ff);
            rsp_v_ff    <= sel_top ? b_lh_ff : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_record_kind = rsp_kind_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_tex_u       = rsp_u_ff;
   assign rsp_tex_v       = rsp_v_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
